// ----- rtl/core/bcgd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcgd_pkg
// Shared types and constants for the button click gesture decoder.
// ----------------------------------------------------------------------------
package bcgd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgLongPress = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgClickGap  = CfgIdxW'(1);

  localparam logic [LimitW-1:0] LongPressRst = LimitW'(1000);
  localparam logic [LimitW-1:0] ClickGapRst  = LimitW'(300);
  localparam logic [CountW-1:0] CountMax     = '1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LONG   = 2'd1,
    EV_CLICKS = 2'd2
  } event_e;

  typedef struct packed {
    logic [LimitW-1:0] long_press_ms;
    logic [LimitW-1:0] multi_click_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic             pressed;
    logic [TimeW-1:0] now_ms;
  } item_t;

endpackage

// ----- rtl/core/bcgd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bcgd_cfg_regs
// Configuration register file: long-press limit and multi-click gap.
// ----------------------------------------------------------------------------
module bcgd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [bcgd_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [bcgd_pkg::LimitW-1:0]  wr_data_i,
  output bcgd_pkg::cfg_t               cfg_o
);
  import bcgd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CfgLongPress: cfg_d.long_press_ms      = wr_data_i;
        CfgClickGap:  cfg_d.multi_click_gap_ms = wr_data_i;
        default:      cfg_d                    = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms      <= LongPressRst;
      cfg_q.multi_click_gap_ms <= ClickGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/bcgd_in_reg.sv -----
// ----------------------------------------------------------------------------
// bcgd_in_reg
// Input register stage; holds one item until the engine takes it.
// ----------------------------------------------------------------------------
module bcgd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  bcgd_pkg::item_t in_item_i,
  input  logic            advance_i,
  output logic            in_stall_o,
  output logic            valid_o,
  output bcgd_pkg::item_t item_o
);
  import bcgd_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/core/bcgd_engine.sv -----
// ----------------------------------------------------------------------------
// bcgd_engine
// Gesture state, per-item update logic and the result register.
// ----------------------------------------------------------------------------
module bcgd_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  bcgd_pkg::item_t             item_i,
  input  bcgd_pkg::cfg_t              cfg_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output bcgd_pkg::event_e            event_o,
  output logic [bcgd_pkg::CountW-1:0] count_o
);
  import bcgd_pkg::*;

  logic [TimeW-1:0]  press_time_q, press_time_d;
  logic [TimeW-1:0]  release_time_q, release_time_d;
  logic [CountW-1:0] clicks_q, clicks_d;
  logic              held_q, held_d;
  logic              gap_wait_q, gap_wait_d;
  logic              long_seen_q, long_seen_d;
  logic              out_valid_q;
  event_e            ev_q, ev_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]  held_for, idle_for;
  logic              long_hit, gap_hit;

  assign held_for = item_i.now_ms - press_time_q;
  assign idle_for = item_i.now_ms - release_time_q;
  assign long_hit = held_for > {{(TimeW-LimitW){1'b0}}, cfg_i.long_press_ms};
  assign gap_hit  = idle_for > {{(TimeW-LimitW){1'b0}}, cfg_i.multi_click_gap_ms};

  always_comb begin
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    clicks_d       = clicks_q;
    held_d         = held_q;
    gap_wait_d     = gap_wait_q;
    long_seen_d    = long_seen_q;
    ev_d           = EV_NONE;
    cnt_d          = '0;
    if (item_i.pressed) begin
      if (!held_q) begin
        press_time_d = item_i.now_ms;
        held_d       = 1'b1;
        gap_wait_d   = 1'b0;
        if (clicks_q != CountMax) begin
          clicks_d = clicks_q + CountW'(1);
        end
      end else if (long_hit && !long_seen_q) begin
        long_seen_d = 1'b1;
        ev_d        = EV_LONG;
      end
    end else begin
      if (held_q) begin
        release_time_d = item_i.now_ms;
        held_d         = 1'b0;
        gap_wait_d     = 1'b1;
      end else if (gap_wait_q && gap_hit) begin
        if (!long_seen_q) begin
          ev_d  = EV_CLICKS;
          cnt_d = clicks_q;
        end
        press_time_d   = '0;
        release_time_d = '0;
        clicks_d       = '0;
        held_d         = 1'b0;
        gap_wait_d     = 1'b0;
        long_seen_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q   <= '0;
      release_time_q <= '0;
      clicks_q       <= '0;
      held_q         <= 1'b0;
      gap_wait_q     <= 1'b0;
      long_seen_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (item_valid_i) begin
        press_time_q   <= press_time_d;
        release_time_q <= release_time_d;
        clicks_q       <= clicks_d;
        held_q         <= held_d;
        gap_wait_q     <= gap_wait_d;
        long_seen_q    <= long_seen_d;
      end
      if (out_ready_i) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      ev_q  <= ev_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_o     = ev_q;
  assign count_o     = cnt_q;

  // A new item only enters when the result register can take it.
  a_item_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i |-> out_ready_i)
    else $error("item entered engine while result register full");

  a_held_excl_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(held_q && gap_wait_q))
    else $error("held and gap wait both set");

  a_idle_no_clicks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clicks_q == '0) |-> (!held_q && !gap_wait_q && !long_seen_q))
    else $error("sequence flags set with zero clicks");

  a_count_only_clicks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q != EV_CLICKS) |-> (cnt_q == '0))
    else $error("click count nonzero on non-click result");

  a_clicks_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q == EV_CLICKS) |-> (cnt_q != '0))
    else $error("click sequence reported with zero clicks");

endmodule

// ----- rtl/core/button_click_gesture_decoder.sv -----
// ----------------------------------------------------------------------------
// button_click_gesture_decoder
// Multi-click and long-press detector over timestamped button samples.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | pressed_i, now_ms_i
//  out     | source    | out_valid_o / out_stall_i| event_res_o, click_count_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One item per clock sustained while out_stall_i is low; an accepted item
//  goes through the input register and then the result register, which
//  drives its result on the outputs.
//  Reset clears the gesture state and loads the default limits
//  (long press 1000 ms, click gap 300 ms); no clearing pass.
//  A stalled result holds; the input register keeps accepting until it is
//  also full, then in_stall_o follows out_stall_i.
// ----------------------------------------------------------------------------
module button_click_gesture_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         pressed_i,
  input  logic [bcgd_pkg::TimeW-1:0]   now_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   event_res_o,
  output logic [bcgd_pkg::CountW-1:0]  click_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bcgd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcgd_pkg::LimitW-1:0]  cfg_data_i
);
  import bcgd_pkg::*;

  cfg_t   cfg;
  item_t  in_item, s1_item;
  logic   s1_valid;
  logic   out_ready;
  logic   out_valid;
  event_e ev;

  assign cfg_ready_o = 1'b1;
  assign in_item     = '{pressed: pressed_i, now_ms: now_ms_i};
  assign out_ready   = !out_valid || !out_stall_i;

  bcgd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bcgd_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .advance_i  (out_ready),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  bcgd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid && out_ready),
    .item_i       (s1_item),
    .cfg_i        (cfg),
    .out_ready_i  (out_ready),
    .out_valid_o  (out_valid),
    .event_o      (ev),
    .count_o      (click_count_o)
  );

  assign out_valid_o = out_valid;
  assign event_res_o = ev;

endmodule
